FILE: sv/lcd4_pkg.sv
// Shared types, constants and the step decoder for the 4-bit character LCD
// write sequencer. No dependencies; used by lcd4_ctrl, lcd4_datapath and the top.
`timescale 1ns / 1ps
`default_nettype none

package lcd4_pkg;

    localparam int HOLD_W = 20;
    localparam int STEP_W = 5;
    localparam int PROD_W = 18;

    // init runs 17 nibble steps: power-up, 12 nibbles, clear byte, home byte
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd16;
    localparam logic [9:0]        MS_TO_US       = 10'd1000;

    localparam int unsigned SOFT_RESET1_MS_DEF = 5;
    localparam int unsigned SOFT_RESET2_MS_DEF = 1;
    localparam int unsigned SOFT_RESET3_MS_DEF = 1;
    localparam int unsigned LINE2_BASE_DEF     = 64;

    localparam logic [7:0] ENABLE_US_RST    = 8'd20;
    localparam logic [9:0] WRITEDATA_US_RST = 10'd46;
    localparam logic [9:0] COMMAND_US_RST   = 10'd42;
    localparam logic [7:0] BOOTUP_MS_RST    = 8'd15;
    localparam logic [7:0] CLEAR_MS_RST     = 8'd2;
    localparam logic [7:0] HOME_MS_RST      = 8'd2;
    localparam logic [6:0] LINE3_BASE_RST   = 7'd20;
    localparam logic [6:0] LINE4_BASE_RST   = 7'd84;

    localparam logic [7:0] DDRAM_SET = 8'h80;

    // phase within one nibble: setup, strobe high, hold
    localparam logic [1:0] PH_SETUP  = 2'd0;
    localparam logic [1:0] PH_STROBE = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;

    typedef enum logic [2:0] {
        REQ_DATA   = 3'd0,
        REQ_CMD    = 3'd1,
        REQ_INIT   = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_HOME   = 3'd4,
        REQ_CURSOR = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        REG_ENABLE_US    = 3'd0,
        REG_WRITEDATA_US = 3'd1,
        REG_COMMAND_US   = 3'd2,
        REG_BOOTUP_MS    = 3'd3,
        REG_CLEAR_MS     = 3'd4,
        REG_HOME_MS      = 3'd5,
        REG_LINE3_BASE   = 3'd6,
        REG_LINE4_BASE   = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        NIB_CONST = 2'd0,
        NIB_HI    = 2'd1,
        NIB_LO    = 2'd2
    } nib_src_t;

    typedef enum logic [1:0] {
        ADD_NONE = 2'd0,
        ADD_WD   = 2'd1,
        ADD_CMD  = 2'd2
    } add_t;

    typedef enum logic [2:0] {
        MS_NONE  = 3'd0,
        MS_BOOT  = 3'd1,
        MS_CLEAR = 3'd2,
        MS_HOME  = 3'd3,
        MS_SR1   = 3'd4,
        MS_SR2   = 3'd5,
        MS_SR3   = 3'd6
    } ms_t;

    // one nibble step: the wait terms apply to its hold phase only
    typedef struct packed {
        logic     rs;
        nib_src_t nib_src;
        logic [3:0] nib_const;
        logic     single;     // lone phase, no strobe, no enable hold
        logic     add_wd;
        add_t     add2;
        ms_t      ms_sel;
        logic     last_step;
    } uop_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        uop_t       uop;
        logic [1:0] phase;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic uop_t uop_lookup(input req_t req, input logic [STEP_W-1:0] step);
        uop_t u;
        u = '{rs: 1'b0, nib_src: NIB_CONST, nib_const: 4'h0, single: 1'b0,
              add_wd: 1'b0, add2: ADD_NONE, ms_sel: MS_NONE, last_step: 1'b0};
        if (req == REQ_INIT) begin
            case (step)
                5'd0: begin
                    u.single = 1'b1;
                    u.ms_sel = MS_BOOT;
                end
                5'd1: begin
                    u.nib_const = 4'h3;
                    u.ms_sel    = MS_SR1;
                end
                5'd2: begin
                    u.nib_const = 4'h3;
                    u.ms_sel    = MS_SR2;
                end
                5'd3: begin
                    u.nib_const = 4'h3;
                    u.ms_sel    = MS_SR3;
                end
                5'd4: begin
                    u.nib_const = 4'h2;
                    u.add2      = ADD_CMD;
                end
                5'd5:  u.nib_const = 4'h2;
                5'd6: begin
                    u.nib_const = 4'hC;
                    u.add2      = ADD_CMD;
                end
                5'd7:  u.nib_const = 4'h0;
                5'd8: begin
                    u.nib_const = 4'hC;
                    u.add2      = ADD_CMD;
                end
                5'd9:  u.nib_const = 4'h0;
                5'd10: begin
                    u.nib_const = 4'h1;
                    u.add2      = ADD_CMD;
                end
                5'd11: u.nib_const = 4'h0;
                5'd12: begin
                    u.nib_const = 4'h2;
                    u.add2      = ADD_CMD;
                end
                5'd13: begin
                    u.nib_const = 4'h0;
                    u.add_wd    = 1'b1;
                end
                5'd14: begin
                    u.nib_const = 4'h1;
                    u.add_wd    = 1'b1;
                    u.add2      = ADD_CMD;
                    u.ms_sel    = MS_CLEAR;
                end
                5'd15: begin
                    u.nib_const = 4'h0;
                    u.add_wd    = 1'b1;
                end
                default: begin
                    u.nib_const = 4'h2;
                    u.add_wd    = 1'b1;
                    u.add2      = ADD_CMD;
                    u.ms_sel    = MS_HOME;
                    u.last_step = 1'b1;
                end
            endcase
        end else begin
            u.rs     = (req == REQ_DATA);
            u.add_wd = 1'b1;
            if (!step[0]) begin
                if (req != REQ_CLEAR && req != REQ_HOME) begin
                    u.nib_src = NIB_HI;
                end
            end else begin
                u.last_step = 1'b1;
                if (req == REQ_DATA) begin
                    u.add2 = ADD_WD;
                end else begin
                    u.add2 = ADD_CMD;
                end
                case (req)
                    REQ_CLEAR: begin
                        u.nib_const = 4'h1;
                        u.ms_sel    = MS_CLEAR;
                    end
                    REQ_HOME: begin
                        u.nib_const = 4'h2;
                        u.ms_sel    = MS_HOME;
                    end
                    default: u.nib_src = NIB_LO;
                endcase
            end
        end
        return u;
    endfunction

endpackage

`default_nettype wire

FILE: sv/lcd4_ctrl.sv
// Sequencer state machine: walks the nibble steps of a request and the three
// phases of each nibble. Depends on lcd4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcd4_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [2:0]       in_req,
    input  wire logic [7:0]       in_row,
    input  wire lcd4_pkg::status_t status,
    output lcd4_pkg::cmd_t        cmd
);

    lcd4_pkg::state_t state_reg, state_next;
    lcd4_pkg::req_t   req_reg, req_next;
    logic [lcd4_pkg::STEP_W-1:0] step_reg, step_next;
    logic [1:0] phase_reg, phase_next;
    logic       req_ok;
    logic       nib_done;
    lcd4_pkg::uop_t uop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcd4_pkg::ST_IDLE;
            req_reg   <= lcd4_pkg::REQ_DATA;
            step_reg  <= '0;
            phase_reg <= lcd4_pkg::PH_SETUP;
        end else begin
            state_reg <= state_next;
            req_reg   <= req_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        // unknown types and cursor rows past 3 are taken and dropped
        req_ok = (in_req inside {lcd4_pkg::REQ_DATA, lcd4_pkg::REQ_CMD, lcd4_pkg::REQ_INIT,
                                 lcd4_pkg::REQ_CLEAR, lcd4_pkg::REQ_HOME})
              || (in_req == lcd4_pkg::REQ_CURSOR && in_row <= 8'd3);
        uop      = lcd4_pkg::uop_lookup(req_reg, step_reg);
        nib_done = uop.single || (phase_reg == lcd4_pkg::PH_HOLD);

        state_next = state_reg;
        req_next   = req_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.uop    = uop;
        cmd.phase  = phase_reg;
        cmd.last   = uop.last_step && nib_done;

        case (state_reg)
            lcd4_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    req_next   = lcd4_pkg::req_t'(in_req);
                    step_next  = '0;
                    phase_next = lcd4_pkg::PH_SETUP;
                    if (req_ok) begin
                        state_next = lcd4_pkg::ST_RUN;
                    end
                end
            end
            lcd4_pkg::ST_RUN: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (nib_done) begin
                        phase_next = lcd4_pkg::PH_SETUP;
                        if (uop.last_step) begin
                            state_next = lcd4_pkg::ST_IDLE;
                        end else begin
                            step_next = step_reg + 1'b1;
                        end
                    end else begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end
            default: state_next = lcd4_pkg::ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("beat issued into a full output register");
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lcd4_pkg::ST_RUN |-> phase_reg <= lcd4_pkg::PH_HOLD)
        else $error("phase counter out of range");
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lcd4_pkg::ST_RUN |-> step_reg <= lcd4_pkg::INIT_LAST_STEP)
        else $error("step counter ran past the init sequence");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && cmd.last |=> state_reg == lcd4_pkg::ST_IDLE)
        else $error("sequencer kept running after the last beat");
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lcd4_pkg::ST_RUN |-> !cmd.load)
        else $error("request loaded while a run is in progress");
`endif

endmodule

`default_nettype wire

FILE: sv/lcd4_datapath.sv
// Datapath: configuration registers, captured byte, hold-time arithmetic and
// the output beat register. Depends on lcd4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcd4_datapath #(
    parameter int unsigned SOFT_RESET1_MS = lcd4_pkg::SOFT_RESET1_MS_DEF,
    parameter int unsigned SOFT_RESET2_MS = lcd4_pkg::SOFT_RESET2_MS_DEF,
    parameter int unsigned SOFT_RESET3_MS = lcd4_pkg::SOFT_RESET3_MS_DEF,
    parameter int unsigned LINE2_BASE     = lcd4_pkg::LINE2_BASE_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [2:0]                  cfg_addr,
    input  wire logic [9:0]                  cfg_wdata,
    input  wire logic [2:0]                  in_req,
    input  wire logic [7:0]                  in_byte,
    input  wire logic [7:0]                  in_column,
    input  wire logic [7:0]                  in_row,
    input  wire lcd4_pkg::cmd_t              cmd,
    output lcd4_pkg::status_t                status,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             out_rs,
    output logic                             out_en,
    output logic [3:0]                       out_nibble,
    output logic [lcd4_pkg::HOLD_W-1:0]      out_hold,
    output logic                             out_last
);

    localparam logic [7:0] SR1_MS   = 8'(SOFT_RESET1_MS);
    localparam logic [7:0] SR2_MS   = 8'(SOFT_RESET2_MS);
    localparam logic [7:0] SR3_MS   = 8'(SOFT_RESET3_MS);
    localparam logic [6:0] LINE2_AD = 7'(LINE2_BASE);

    logic [7:0] enable_us_reg;
    logic [9:0] writedata_us_reg;
    logic [9:0] command_us_reg;
    logic [7:0] bootup_ms_reg;
    logic [7:0] clear_ms_reg;
    logic [7:0] home_ms_reg;
    logic [6:0] line3_base_reg;
    logic [6:0] line4_base_reg;

    logic [7:0] byte_reg, byte_next;
    logic [6:0] row_base;

    logic       valid_reg;
    logic       rs_reg, en_reg, last_reg;
    logic [3:0] nib_reg, nib_next;
    logic [lcd4_pkg::HOLD_W-1:0] hold_reg, hold_next;

    logic       with_wait;
    logic [7:0] ms_val;
    logic [lcd4_pkg::PROD_W-1:0] ms_prod;
    logic [9:0] wd_term, add2_term;
    logic [7:0] en_term;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_us_reg    <= lcd4_pkg::ENABLE_US_RST;
            writedata_us_reg <= lcd4_pkg::WRITEDATA_US_RST;
            command_us_reg   <= lcd4_pkg::COMMAND_US_RST;
            bootup_ms_reg    <= lcd4_pkg::BOOTUP_MS_RST;
            clear_ms_reg     <= lcd4_pkg::CLEAR_MS_RST;
            home_ms_reg      <= lcd4_pkg::HOME_MS_RST;
            line3_base_reg   <= lcd4_pkg::LINE3_BASE_RST;
            line4_base_reg   <= lcd4_pkg::LINE4_BASE_RST;
        end else if (cfg_wr_en) begin
            case (lcd4_pkg::cfg_reg_t'(cfg_addr))
                lcd4_pkg::REG_ENABLE_US:    enable_us_reg    <= cfg_wdata[7:0];
                lcd4_pkg::REG_WRITEDATA_US: writedata_us_reg <= cfg_wdata;
                lcd4_pkg::REG_COMMAND_US:   command_us_reg   <= cfg_wdata;
                lcd4_pkg::REG_BOOTUP_MS:    bootup_ms_reg    <= cfg_wdata[7:0];
                lcd4_pkg::REG_CLEAR_MS:     clear_ms_reg     <= cfg_wdata[7:0];
                lcd4_pkg::REG_HOME_MS:      home_ms_reg      <= cfg_wdata[7:0];
                lcd4_pkg::REG_LINE3_BASE:   line3_base_reg   <= cfg_wdata[6:0];
                lcd4_pkg::REG_LINE4_BASE:   line4_base_reg   <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // byte to send: either the given byte or the DDRAM address command
    always_comb begin
        case (in_row[1:0])
            2'd0:    row_base = '0;
            2'd1:    row_base = LINE2_AD;
            2'd2:    row_base = line3_base_reg;
            default: row_base = line4_base_reg;
        endcase
        if (in_req == lcd4_pkg::REQ_CURSOR) begin
            byte_next = lcd4_pkg::DDRAM_SET + {1'b0, row_base} + in_column;
        end else begin
            byte_next = in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= byte_next;
        end
    end

    always_comb begin
        case (cmd.uop.nib_src)
            lcd4_pkg::NIB_HI: nib_next = byte_reg[7:4];
            lcd4_pkg::NIB_LO: nib_next = byte_reg[3:0];
            default:          nib_next = cmd.uop.nib_const;
        endcase

        case (cmd.uop.ms_sel)
            lcd4_pkg::MS_BOOT:  ms_val = bootup_ms_reg;
            lcd4_pkg::MS_CLEAR: ms_val = clear_ms_reg;
            lcd4_pkg::MS_HOME:  ms_val = home_ms_reg;
            lcd4_pkg::MS_SR1:   ms_val = SR1_MS;
            lcd4_pkg::MS_SR2:   ms_val = SR2_MS;
            lcd4_pkg::MS_SR3:   ms_val = SR3_MS;
            default:            ms_val = '0;
        endcase

        case (cmd.uop.add2)
            lcd4_pkg::ADD_WD:  add2_term = writedata_us_reg;
            lcd4_pkg::ADD_CMD: add2_term = command_us_reg;
            default:           add2_term = '0;
        endcase

        // settle waits only land on the closing phase of a nibble
        with_wait = cmd.uop.single || (cmd.phase == lcd4_pkg::PH_HOLD);
        wd_term   = cmd.uop.add_wd ? writedata_us_reg : '0;
        en_term   = cmd.uop.single ? '0 : enable_us_reg;
        ms_prod   = lcd4_pkg::PROD_W'(ms_val) * lcd4_pkg::PROD_W'(lcd4_pkg::MS_TO_US);

        if (with_wait) begin
            hold_next = lcd4_pkg::HOLD_W'(en_term) + lcd4_pkg::HOLD_W'(wd_term)
                      + lcd4_pkg::HOLD_W'(add2_term) + lcd4_pkg::HOLD_W'(ms_prod);
        end else begin
            hold_next = lcd4_pkg::HOLD_W'(en_term);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            rs_reg   <= cmd.uop.rs;
            en_reg   <= (cmd.phase == lcd4_pkg::PH_STROBE) && !cmd.uop.single;
            nib_reg  <= nib_next;
            hold_reg <= hold_next;
            last_reg <= cmd.last;
        end
    end

    assign status.out_free = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_rs     = rs_reg;
    assign out_en     = en_reg;
    assign out_nibble = nib_reg;
    assign out_hold   = hold_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

FILE: sv/char_lcd_4bit_write_sequencer_top.sv
// Top level of the 4-bit character LCD write sequencer: joins lcd4_ctrl and
// lcd4_datapath. Depends on lcd4_pkg.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: byte, column, row
//  m_        out  m_tvalid/m_tready  m_tuser: reg_select; m_tdata: en, nibble, hold
//  cfg_      in   cfg_wr_en          cfg_addr: register index; cfg_wdata: value
//
// A request is accepted in ST_IDLE, then one phase beat issues per cycle while
// m_tready is high or no beat is pending: 6 beats for data, command, cursor, clear and
// home, 49 for init; a dropped request issues none. The phase counter in lcd4_ctrl sets the pace.
// aresetn is synchronous and restores the register defaults.
// m_tready low freezes the sequencer with the pending beat held in the output register.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_4bit_write_sequencer_top #(
    parameter int unsigned SOFT_RESET1_MS = lcd4_pkg::SOFT_RESET1_MS_DEF,
    parameter int unsigned SOFT_RESET2_MS = lcd4_pkg::SOFT_RESET2_MS_DEF,
    parameter int unsigned SOFT_RESET3_MS = lcd4_pkg::SOFT_RESET3_MS_DEF,
    parameter int unsigned LINE2_BASE     = lcd4_pkg::LINE2_BASE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [9:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] byte_value, [15:8] column, [23:16] row
    input  wire logic [2:0]  s_tuser,   // [2:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [0] enable_pin, [4:1] nibble, [24:5] hold_us, zeros
    output logic [0:0]       m_tuser,   // [0] reg_select
    output logic             m_tlast
);

    lcd4_pkg::cmd_t    cmd;
    lcd4_pkg::status_t status;
    logic       out_rs, out_en;
    logic [3:0] out_nibble;
    logic [lcd4_pkg::HOLD_W-1:0] out_hold;

    lcd4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (s_tuser),
        .in_row   (s_tdata[23:16]),
        .status   (status),
        .cmd      (cmd)
    );

    lcd4_datapath #(
        .SOFT_RESET1_MS (SOFT_RESET1_MS),
        .SOFT_RESET2_MS (SOFT_RESET2_MS),
        .SOFT_RESET3_MS (SOFT_RESET3_MS),
        .LINE2_BASE     (LINE2_BASE)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_req     (s_tuser),
        .in_byte    (s_tdata[7:0]),
        .in_column  (s_tdata[15:8]),
        .in_row     (s_tdata[23:16]),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rs     (out_rs),
        .out_en     (out_en),
        .out_nibble (out_nibble),
        .out_hold   (out_hold),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'd0, out_hold, out_nibble, out_en};
    assign m_tuser = out_rs;

endmodule

`default_nettype wire

FILE: dv/char_lcd_4bit_write_sequencer_top_test.sv
// Self-checking testbench for char_lcd_4bit_write_sequencer_top: predicts the LCD
// pin phases of each request and checks every m_ beat under random idling.
// Depends on lcd4_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module char_lcd_4bit_write_sequencer_top_test;

    localparam logic [2:0] REQ_SPARE_A = 3'd6;  // no such request: dropped
    localparam logic [2:0] REQ_SPARE_B = 3'd7;
    localparam int unsigned SR1_MS = 5;
    localparam int unsigned SR2_MS = 1;
    localparam int unsigned SR3_MS = 1;
    localparam int unsigned ROW1_BASE = 64;
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME = 8'h02;
    localparam logic [7:0] CMD_DDRAM = 8'h80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] val;
        logic [7:0] col;
        logic [7:0] row;
    } lcd_req_t;

    typedef struct packed {
        logic        rs;
        logic        en;
        logic [3:0]  nib;
        logic [19:0] hold;
        logic        last;
    } pin_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [9:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    // shadow copy of the timing registers, reset values
    int unsigned enable_us = 20;
    int unsigned writedata_us = 46;
    int unsigned command_us = 42;
    int unsigned bootup_ms = 15;
    int unsigned clear_ms = 2;
    int unsigned home_ms = 2;
    int unsigned line3_base = 20;
    int unsigned line4_base = 84;

    lcd_req_t   req_q[$];
    pin_phase_t pin_phase_q[$];
    int err_cnt = 0;
    int src_wait = 0;
    int src_calm = 0;
    int snk_wait = 0;
    int snk_calm = 0;
    int quiet_cycles = 0;

    char_lcd_4bit_write_sequencer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor
    function automatic void add_phase(logic rs, logic en, logic [3:0] nib, int unsigned hold);
        pin_phase_t p;
        p.rs   = rs;
        p.en   = en;
        p.nib  = nib;
        p.hold = hold[19:0];
        p.last = 1'b0;
        pin_phase_q.push_back(p);
    endfunction

    // enable low, high, low; trailing wait rides on the last phase
    function automatic void add_nibble(logic rs, logic [3:0] nib, int unsigned extra);
        add_phase(rs, 1'b0, nib, enable_us);
        add_phase(rs, 1'b1, nib, enable_us);
        add_phase(rs, 1'b0, nib, enable_us + extra);
    endfunction

    function automatic void add_byte(logic rs, logic [7:0] val, int unsigned extra);
        add_nibble(rs, val[7:4], writedata_us);
        add_nibble(rs, val[3:0], writedata_us + extra);
    endfunction

    function automatic void predict_pin_phases(lcd_req_t it);
        int n0;
        int unsigned row_base;
        n0 = pin_phase_q.size();
        case (it.kind)
            lcd4_pkg::REQ_DATA: add_byte(1'b1, it.val, writedata_us);
            lcd4_pkg::REQ_CMD: add_byte(1'b0, it.val, command_us);
            lcd4_pkg::REQ_CLEAR: add_byte(1'b0, CMD_CLEAR, command_us + clear_ms * 1000);
            lcd4_pkg::REQ_HOME: add_byte(1'b0, CMD_HOME, command_us + home_ms * 1000);
            lcd4_pkg::REQ_INIT: begin
                add_phase(1'b0, 1'b0, 4'h0, bootup_ms * 1000);
                add_nibble(1'b0, 4'h3, SR1_MS * 1000);
                add_nibble(1'b0, 4'h3, SR2_MS * 1000);
                add_nibble(1'b0, 4'h3, SR3_MS * 1000);
                add_nibble(1'b0, 4'h2, command_us);
                // function set, display on, clear, return home: settle after each low nibble only
                add_nibble(1'b0, 4'h2, 0);
                add_nibble(1'b0, 4'hC, command_us);
                add_nibble(1'b0, 4'h0, 0);
                add_nibble(1'b0, 4'hC, command_us);
                add_nibble(1'b0, 4'h0, 0);
                add_nibble(1'b0, 4'h1, command_us);
                add_nibble(1'b0, 4'h0, 0);
                add_nibble(1'b0, 4'h2, command_us);
                add_byte(1'b0, CMD_CLEAR, command_us + clear_ms * 1000);
                add_byte(1'b0, CMD_HOME, command_us + home_ms * 1000);
            end
            lcd4_pkg::REQ_CURSOR: begin
                if (it.row <= 8'd3) begin
                    case (it.row)
                        8'd0: row_base = 0;
                        8'd1: row_base = ROW1_BASE;
                        8'd2: row_base = line3_base;
                        default: row_base = line4_base;
                    endcase
                    add_byte(1'b0, 8'((CMD_DDRAM + row_base + it.col) & 8'hFF), command_us);
                end
            end
            default: ;
        endcase
        if (pin_phase_q.size() > n0)
            pin_phase_q[pin_phase_q.size() - 1].last = 1'b1;
    endfunction

    // per-beat wait, with occasional runs of back-to-back beats
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(5, 25);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // ---------------------------------------------------------------- request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pin_phases(req_q.pop_front());
                src_wait = draw_wait(src_calm);
            end
            if (!s_tvalid || s_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {req_q[0].row, req_q[0].col, req_q[0].val};
                    s_tuser  <= req_q[0].kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- phase monitor
    always @(posedge aclk) begin
        pin_phase_t act;
        pin_phase_t exp_ph;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                act = '{rs: m_tuser[0], en: m_tdata[0], nib: m_tdata[4:1],
                        hold: m_tdata[24:5], last: m_tlast};
                if (pin_phase_q.size() == 0) begin
                    err_cnt++;
                    $display({"%0t: unexpected beat: expected none, ",
                              "actual rs=%0d en=%0d nib=%h hold=%0d last=%0d"},
                             $time, act.rs, act.en, act.nib, act.hold, act.last);
                end else begin
                    exp_ph = pin_phase_q.pop_front();
                    if (act !== exp_ph) begin
                        err_cnt++;
                        $display({"%0t: beat mismatch: ",
                                  "expected rs=%0d en=%0d nib=%h hold=%0d last=%0d"},
                                 $time, exp_ph.rs, exp_ph.en, exp_ph.nib, exp_ph.hold,
                                 exp_ph.last);
                        $display({"%0t:                ",
                                  "actual rs=%0d en=%0d nib=%h hold=%0d last=%0d"},
                                 $time, act.rs, act.en, act.nib, act.hold, act.last);
                    end
                end
                snk_wait = draw_wait(snk_calm);
            end
            if (snk_wait > 0) begin
                snk_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** char_lcd_4bit_write_sequencer_top: FAILED **");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence
    task automatic write_reg(lcd4_pkg::cfg_reg_t idx, logic [9:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            lcd4_pkg::REG_ENABLE_US: enable_us = val[7:0];
            lcd4_pkg::REG_WRITEDATA_US: writedata_us = val;
            lcd4_pkg::REG_COMMAND_US: command_us = val;
            lcd4_pkg::REG_BOOTUP_MS: bootup_ms = val[7:0];
            lcd4_pkg::REG_CLEAR_MS: clear_ms = val[7:0];
            lcd4_pkg::REG_HOME_MS: home_ms = val[7:0];
            lcd4_pkg::REG_LINE3_BASE: line3_base = val[6:0];
            default: line4_base = val[6:0];
        endcase
    endtask

    // 0: all zero, 1: all ones (upper bits dropped by narrow registers), else random
    task automatic apply_setting(int sel);
        logic [9:0] v;
        for (int r = 0; r < 8; r++) begin
            v = (sel == 0) ? 10'h000 : (sel == 1) ? 10'h3FF : 10'($urandom_range(0, 1023));
            write_reg(lcd4_pkg::cfg_reg_t'(r[2:0]), v);
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void queue_req(logic [2:0] kind, logic [7:0] val, logic [7:0] col,
                                      logic [7:0] row);
        lcd_req_t it;
        it.kind = kind;
        it.val  = val;
        it.col  = col;
        it.row  = row;
        req_q.push_back(it);
    endfunction

    function automatic void queue_random_req();
        int sel;
        logic [7:0] row;
        logic [2:0] kind;
        sel  = $urandom_range(0, 99);
        row  = 8'($urandom_range(0, 3));
        if (sel < 30) kind = lcd4_pkg::REQ_DATA;
        else if (sel < 50) kind = lcd4_pkg::REQ_CMD;
        else if (sel < 75) kind = lcd4_pkg::REQ_CURSOR;
        else if (sel < 82) kind = lcd4_pkg::REQ_CLEAR;
        else if (sel < 89) kind = lcd4_pkg::REQ_HOME;
        else if (sel < 93) kind = lcd4_pkg::REQ_INIT;
        else if (sel < 97) begin
            kind = lcd4_pkg::REQ_CURSOR;
            row  = 8'($urandom_range(4, 255));
        end else begin
            kind = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
        end
        queue_req(kind, 8'($urandom), 8'($urandom), row);
    endfunction

    task automatic drain();
        while (req_q.size() != 0 || pin_phase_q.size() != 0)
            @(posedge aclk);
        // a dropped request may still be in the sequencer
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset register values
        queue_req(lcd4_pkg::REQ_DATA, 8'h00, 8'h00, 8'h00);
        queue_req(lcd4_pkg::REQ_DATA, 8'hFF, 8'hFF, 8'hFF);
        queue_req(lcd4_pkg::REQ_CMD, 8'hA5, 8'h00, 8'h00);
        queue_req(lcd4_pkg::REQ_CMD, 8'h5A, 8'hFF, 8'hFF);
        queue_req(lcd4_pkg::REQ_INIT, 8'h00, 8'h00, 8'h00);
        queue_req(lcd4_pkg::REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF);
        queue_req(lcd4_pkg::REQ_HOME, 8'h00, 8'h00, 8'h00);
        queue_req(lcd4_pkg::REQ_CURSOR, 8'h00, 8'h00, 8'd0);
        queue_req(lcd4_pkg::REQ_CURSOR, 8'hFF, 8'hFF, 8'd1);
        queue_req(lcd4_pkg::REQ_CURSOR, 8'h00, 8'h6B, 8'd2);
        queue_req(lcd4_pkg::REQ_CURSOR, 8'h00, 8'hFF, 8'd3);   // address wraps past 0xFF
        queue_req(lcd4_pkg::REQ_CURSOR, 8'h00, 8'h00, 8'd4);   // row out of range
        queue_req(lcd4_pkg::REQ_CURSOR, 8'hFF, 8'hFF, 8'hFF);
        queue_req(REQ_SPARE_A, 8'($urandom), 8'($urandom), 8'($urandom));
        queue_req(REQ_SPARE_B, 8'($urandom), 8'($urandom), 8'($urandom));
        queue_req(lcd4_pkg::REQ_DATA, 8'h3C, 8'h00, 8'h00);
        drain();

        for (int s = 0; s < 4; s++) begin
            apply_setting(s);
            @(negedge aclk);
            queue_req(lcd4_pkg::REQ_INIT, 8'($urandom), 8'($urandom), 8'($urandom));
            for (int k = 0; k < 41; k++)
                queue_random_req();
            drain();
        end

        if (err_cnt == 0 && pin_phase_q.size() == 0)
            $display("** char_lcd_4bit_write_sequencer_top: PASSED **");
        else
            $display("** char_lcd_4bit_write_sequencer_top: FAILED **");
        $finish;
    end

endmodule
